// ----- hw/rtl/pdf_pkg.sv -----
`timescale 1ns / 1ps

package pdf_pkg;

    localparam int DEPTH_DEFAULT   = 1024;
    localparam int STREAMS_DEFAULT = 16;

    localparam logic [31:0] BYTE_LIMIT_RESET = 32'd314572800;
    localparam logic [7:0]  OVERHEAD_RESET   = 8'd96;

    localparam int SIZE_W   = 24;
    localparam int STREAM_W = 4;
    localparam int HANDLE_W = 32;
    localparam int COUNT_W  = 11;
    localparam int BYTES_W  = 33;
    localparam int LIMIT_W  = 32;
    localparam int OVH_W    = 8;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 120;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_GET   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC
    } state_t;

    localparam logic REG_BYTE_LIMIT = 1'b0;
    localparam logic REG_OVERHEAD   = 1'b1;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STREAM_W-1:0] stream;
        logic [SIZE_W-1:0]   size;
    } entry_t;

endpackage

// ----- hw/rtl/packet_descriptor_fifo.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: size, stream, handle; tuser: mode
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: results; tuser: ok
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// every item passes in order through descriptor store read, per-stream counter read, update
// the next item is accepted once the update cycle has loaded the output register
// a result waits in the output register; a full register stalls only the update cycle
// rst_n clears pointers, counters and counter valid bits; the store holds no reset
// configuration writes are always taken (cfg_ready tied high)

module packet_descriptor_fifo #(
    parameter int DEPTH   = pdf_pkg::DEPTH_DEFAULT,
    parameter int STREAMS = pdf_pkg::STREAMS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pkt_size[23:0], stream_id[27:24], pkt_handle[59:28], zero[63:60]
    input  logic [pdf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_size[23:0], out_stream[27:24], out_handle[59:28], entry_count[70:60],
    // byte_total[103:71], stream_count[114:104], zero[119:115]
    output logic [pdf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // ok[0]
    output logic                             m_axis_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [31:0]                      cfg_data
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int SIW  = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    // storage
    pdf_pkg::entry_t   store_mem [DEPTH];
    logic [CNTW-1:0]   strm_mem  [STREAMS];
    logic [STREAMS-1:0] strm_vld_reg;

    pdf_pkg::state_t   state_reg, state_next;

    logic [PW-1:0]     head_ptr_reg, head_ptr_next;
    logic [PW-1:0]     tail_ptr_reg, tail_ptr_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [pdf_pkg::BYTES_W-1:0] bytes_reg, bytes_next;
    logic [pdf_pkg::LIMIT_W-1:0] byte_limit_reg;
    logic [pdf_pkg::OVH_W-1:0]   overhead_reg;

    // latched item
    pdf_pkg::mode_t    mode_reg;
    pdf_pkg::entry_t   item_reg;

    // memory read data
    pdf_pkg::entry_t   store_rdata_reg;
    logic [CNTW-1:0]   strm_rdata_reg;
    logic              strm_rvld_reg;

    // output register
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [pdf_pkg::SIZE_W-1:0]   out_size_reg;
    logic [pdf_pkg::STREAM_W-1:0] out_stream_reg;
    logic [pdf_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [CNTW-1:0]   out_count_reg;
    logic [pdf_pkg::BYTES_W-1:0]  out_bytes_reg;
    logic [CNTW-1:0]   out_scount_reg;

    logic              out_ok_next;
    logic [CNTW-1:0]   out_scount_next;
    pdf_pkg::entry_t   out_entry_next;

    logic              in_fire;
    logic              exec_fire;
    logic [SIW-1:0]    strm_raddr;
    logic [SIW-1:0]    strm_waddr;
    logic              strm_we;
    logic [CNTW-1:0]   strm_wdata;
    logic              strm_clear;
    logic              store_we;

    logic              sid_ok;
    logic              get_sid_ok;
    logic [CNTW-1:0]   cnt_base;
    logic              room;
    logic              fits;
    logic [pdf_pkg::BYTES_W:0] put_sum;
    logic [pdf_pkg::BYTES_W:0] fit_sum;
    logic [pdf_pkg::BYTES_W-1:0] charge;

    assign s_axis_tready = (state_reg == pdf_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign exec_fire     = (state_reg == pdf_pkg::ST_EXEC) && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {5'b0,
                            pdf_pkg::COUNT_W'(out_scount_reg),
                            out_bytes_reg,
                            pdf_pkg::COUNT_W'(out_count_reg),
                            out_handle_reg,
                            out_stream_reg,
                            out_size_reg};

    // get reads the counter of the stream just fetched from the store
    assign strm_raddr = (mode_reg == pdf_pkg::MODE_GET) ? SIW'(store_rdata_reg.stream)
                                                        : SIW'(item_reg.stream);

    assign sid_ok     = (32'(item_reg.stream) < STREAMS);
    assign get_sid_ok = (32'(store_rdata_reg.stream) < STREAMS);
    assign cnt_base   = strm_rvld_reg ? strm_rdata_reg : '0;
    assign room       = (32'(count_reg) < DEPTH);
    assign fit_sum    = {1'b0, bytes_reg} + (pdf_pkg::BYTES_W + 1)'(item_reg.size);
    assign fits       = (fit_sum <= (pdf_pkg::BYTES_W + 1)'(byte_limit_reg));
    assign put_sum    = fit_sum + (pdf_pkg::BYTES_W + 1)'(overhead_reg);
    assign charge     = pdf_pkg::BYTES_W'(store_rdata_reg.size)
                      + pdf_pkg::BYTES_W'(overhead_reg);

    always_comb
    begin
        state_next      = state_reg;
        head_ptr_next   = head_ptr_reg;
        tail_ptr_next   = tail_ptr_reg;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        out_ok_next     = 1'b0;
        out_scount_next = '0;
        out_entry_next  = '0;
        store_we        = 1'b0;
        strm_we         = 1'b0;
        strm_waddr      = SIW'(item_reg.stream);
        strm_wdata      = cnt_base;
        strm_clear      = 1'b0;

        unique case (state_reg)
            pdf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = pdf_pkg::ST_FETCH;
                end
            end
            pdf_pkg::ST_FETCH:
            begin
                state_next = pdf_pkg::ST_EXEC;
            end
            pdf_pkg::ST_EXEC:
            begin
                case (mode_reg)
                    pdf_pkg::MODE_PUT:
                    begin
                        if (room && fits && sid_ok)
                        begin
                            store_we      = 1'b1;
                            tail_ptr_next = (tail_ptr_reg == PW'(DEPTH - 1)) ? '0
                                                                             : tail_ptr_reg + 1'b1;
                            count_next    = count_reg + 1'b1;
                            bytes_next    = put_sum[pdf_pkg::BYTES_W-1:0];
                            strm_we       = 1'b1;
                            strm_wdata    = cnt_base + 1'b1;
                            out_ok_next   = 1'b1;
                        end
                    end
                    pdf_pkg::MODE_GET:
                    begin
                        if (count_reg != '0)
                        begin
                            head_ptr_next  = (head_ptr_reg == PW'(DEPTH - 1)) ? '0
                                                                              : head_ptr_reg + 1'b1;
                            count_next     = count_reg - 1'b1;
                            bytes_next     = (bytes_reg >= charge) ? bytes_reg - charge : '0;
                            strm_waddr     = SIW'(store_rdata_reg.stream);
                            strm_we        = get_sid_ok && (cnt_base != '0);
                            strm_wdata     = cnt_base - 1'b1;
                            out_ok_next    = 1'b1;
                            out_entry_next = store_rdata_reg;
                        end
                    end
                    pdf_pkg::MODE_CLEAR:
                    begin
                        head_ptr_next = '0;
                        tail_ptr_next = '0;
                        count_next    = '0;
                        bytes_next    = '0;
                        strm_clear    = 1'b1;
                    end
                    default:
                    begin
                        if (sid_ok)
                        begin
                            out_scount_next = cnt_base;
                        end
                    end
                endcase
                if (exec_fire)
                begin
                    state_next = pdf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pdf_pkg::ST_IDLE;
            head_ptr_reg   <= '0;
            tail_ptr_reg   <= '0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            strm_vld_reg   <= '0;
            out_valid_reg  <= 1'b0;
            byte_limit_reg <= pdf_pkg::BYTE_LIMIT_RESET;
            overhead_reg   <= pdf_pkg::OVERHEAD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                head_ptr_reg <= head_ptr_next;
                tail_ptr_reg <= tail_ptr_next;
                count_reg    <= count_next;
                bytes_reg    <= bytes_next;
                if (strm_clear)
                begin
                    strm_vld_reg <= '0;
                end
                else if (strm_we)
                begin
                    strm_vld_reg[strm_waddr] <= 1'b1;
                end
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pdf_pkg::REG_BYTE_LIMIT: byte_limit_reg <= cfg_data;
                    pdf_pkg::REG_OVERHEAD:   overhead_reg   <= cfg_data[pdf_pkg::OVH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // item latch, output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg         <= pdf_pkg::mode_t'(s_axis_tuser);
            item_reg.size    <= s_axis_tdata[23:0];
            item_reg.stream  <= s_axis_tdata[27:24];
            item_reg.handle  <= s_axis_tdata[59:28];
        end
        if (exec_fire)
        begin
            out_ok_reg     <= out_ok_next;
            out_size_reg   <= out_entry_next.size;
            out_stream_reg <= out_entry_next.stream;
            out_handle_reg <= out_entry_next.handle;
            out_count_reg  <= count_next;
            out_bytes_reg  <= bytes_next;
            out_scount_reg <= out_scount_next;
        end
    end

    // descriptor store
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            store_rdata_reg <= store_mem[head_ptr_reg];
        end
        if (exec_fire && store_we)
        begin
            store_mem[tail_ptr_reg] <= item_reg;
        end
    end

    // per-stream counters
    always_ff @(posedge clk)
    begin
        if (state_reg == pdf_pkg::ST_FETCH)
        begin
            strm_rdata_reg <= strm_mem[strm_raddr];
            strm_rvld_reg  <= strm_vld_reg[strm_raddr];
        end
        if (exec_fire && strm_we && !strm_clear)
        begin
            strm_mem[strm_waddr] <= strm_wdata;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("entry count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_ptr_reg == tail_ptr_reg))
        else $error("empty queue with pointers apart");

    a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == pdf_pkg::ST_FETCH))
        else $error("accepted item did not start a fetch");

    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == pdf_pkg::ST_EXEC))
        else $error("result loaded outside the update cycle");
`endif

endmodule

// ----- test/packet_descriptor_fifo_tb.sv -----
`timescale 1ns / 1ps

module packet_descriptor_fifo_tb;

    localparam int DEPTH       = pdf_pkg::DEPTH_DEFAULT;
    localparam int STREAMS     = pdf_pkg::STREAMS_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        pdf_pkg::mode_t               mode;
        logic [pdf_pkg::SIZE_W-1:0]   size;
        logic [pdf_pkg::STREAM_W-1:0] stream;
        logic [pdf_pkg::HANDLE_W-1:0] handle;
    } descriptor_op_t;

    typedef struct {
        logic                         ok;
        logic [pdf_pkg::SIZE_W-1:0]   size;
        logic [pdf_pkg::STREAM_W-1:0] stream;
        logic [pdf_pkg::HANDLE_W-1:0] handle;
        logic [pdf_pkg::COUNT_W-1:0]  count;
        logic [pdf_pkg::BYTES_W-1:0]  bytes;
        logic [pdf_pkg::COUNT_W-1:0]  stream_count;
    } fifo_result_t;

    logic                           clk;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [pdf_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]                     s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [pdf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic                           cfg_index     = 1'b0;
    logic [31:0]                    cfg_data      = '0;

    // predictor state
    logic [pdf_pkg::SIZE_W-1:0]     slot_size   [DEPTH];
    logic [pdf_pkg::STREAM_W-1:0]   slot_stream [DEPTH];
    logic [pdf_pkg::HANDLE_W-1:0]   slot_handle [DEPTH];
    int                             rd_ptr;
    int                             wr_ptr;
    logic [pdf_pkg::COUNT_W-1:0]    held_count;
    logic [pdf_pkg::BYTES_W-1:0]    charged_bytes;
    logic [pdf_pkg::COUNT_W-1:0]    stream_tally [STREAMS];
    logic [pdf_pkg::LIMIT_W-1:0]    limit_reg;
    logic [pdf_pkg::OVH_W-1:0]      overhead_reg;

    descriptor_op_t        pending_ops [$];
    fifo_result_t          expected_results [$];
    descriptor_op_t        op_on_bus;
    fifo_result_t          next_result;
    int                    outstanding = 0;
    int                    error_count = 0;
    int                    results_seen = 0;
    int                    cycle_count = 0;
    logic                  no_idle = 1'b0;

    packet_descriptor_fifo dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_queue_state();
        rd_ptr        = 0;
        wr_ptr        = 0;
        held_count    = '0;
        charged_bytes = '0;
        for (int s = 0; s < STREAMS; s++)
            stream_tally[s] = '0;
    endfunction

    function automatic fifo_result_t apply_descriptor_op(descriptor_op_t op);
        fifo_result_t r;
        logic [34:0]  fill;
        logic [33:0]  release_bytes;
        r = '{default: '0};
        case (op.mode)
            pdf_pkg::MODE_PUT:
            begin
                fill = 35'(charged_bytes) + 35'(op.size);
                if (held_count < DEPTH && fill <= 35'(limit_reg) && op.stream < STREAMS)
                begin
                    slot_size[wr_ptr]   = op.size;
                    slot_stream[wr_ptr] = op.stream;
                    slot_handle[wr_ptr] = op.handle;
                    wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
                    held_count++;
                    charged_bytes = pdf_pkg::BYTES_W'(fill + 35'(overhead_reg));
                    stream_tally[op.stream]++;
                    r.ok = 1'b1;
                end
            end
            pdf_pkg::MODE_GET:
            begin
                if (held_count != 0)
                begin
                    r.ok     = 1'b1;
                    r.size   = slot_size[rd_ptr];
                    r.stream = slot_stream[rd_ptr];
                    r.handle = slot_handle[rd_ptr];
                    // release uses the overhead in force now, floor at zero
                    release_bytes = 34'(r.size) + 34'(overhead_reg);
                    if (34'(charged_bytes) >= release_bytes)
                        charged_bytes = pdf_pkg::BYTES_W'(34'(charged_bytes) - release_bytes);
                    else
                        charged_bytes = '0;
                    if (stream_tally[r.stream] != 0)
                        stream_tally[r.stream]--;
                    rd_ptr = (rd_ptr == DEPTH - 1) ? 0 : rd_ptr + 1;
                    held_count--;
                end
            end
            pdf_pkg::MODE_CLEAR:
                clear_queue_state();
            default:
            begin
                if (op.stream < STREAMS)
                    r.stream_count = stream_tally[op.stream];
            end
        endcase
        r.count = held_count;
        r.bytes = charged_bytes;
        return r;
    endfunction

    function automatic descriptor_op_t random_op(int big_pct);
        descriptor_op_t op;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            op.mode = pdf_pkg::MODE_PUT;
        else if (pick < 85)
            op.mode = pdf_pkg::MODE_GET;
        else if (pick < 88)
            op.mode = pdf_pkg::MODE_CLEAR;
        else
            op.mode = pdf_pkg::MODE_QUERY;
        if ($urandom_range(0, 99) < big_pct)
            op.size = pdf_pkg::SIZE_W'($urandom);
        else
            op.size = pdf_pkg::SIZE_W'($urandom_range(0, 3000));
        op.stream = pdf_pkg::STREAM_W'($urandom);
        op.handle = $urandom;
        return op;
    endfunction

    task automatic queue_op(descriptor_op_t op);
        pending_ops.push_back(op);
        outstanding++;
    endtask

    task automatic queue_fixed(pdf_pkg::mode_t m, int unsigned size, int unsigned stream,
                               logic [pdf_pkg::HANDLE_W-1:0] handle);
        descriptor_op_t op;
        op.mode   = m;
        op.size   = pdf_pkg::SIZE_W'(size);
        op.stream = pdf_pkg::STREAM_W'(stream);
        op.handle = handle;
        queue_op(op);
    endtask

    task automatic wait_for_drain();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == pdf_pkg::REG_BYTE_LIMIT)
            limit_reg = value;
        else
            overhead_reg = value[pdf_pkg::OVH_W-1:0];
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_descriptor_op(op_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ops.size() != 0 && (no_idle || $urandom_range(0, 99) >= 30))
                begin
                    op_on_bus = pending_ops.pop_front();
                    s_axis_tdata  <= {4'b0000, op_on_bus.handle, op_on_bus.stream,
                                      op_on_bus.size};
                    s_axis_tuser  <= op_on_bus.mode;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result item with nothing expected");
                end
                else
                begin
                    next_result = expected_results.pop_front();
                    check_field("ok", m_axis_tuser, next_result.ok);
                    check_field("out_size", m_axis_tdata[23:0], next_result.size);
                    check_field("out_stream", m_axis_tdata[27:24], next_result.stream);
                    check_field("out_handle", m_axis_tdata[59:28], next_result.handle);
                    check_field("entry_count", m_axis_tdata[70:60], next_result.count);
                    check_field("byte_total", m_axis_tdata[103:71], next_result.bytes);
                    check_field("stream_count", m_axis_tdata[114:104],
                                next_result.stream_count);
                    outstanding--;
                end
                results_seen++;
            end
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        descriptor_op_t op;

        clear_queue_state();
        limit_reg    = pdf_pkg::BYTE_LIMIT_RESET;
        overhead_reg = pdf_pkg::OVERHEAD_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: empty get, extremes, clear
        queue_fixed(pdf_pkg::MODE_GET, 0, 0, 32'h0);
        queue_fixed(pdf_pkg::MODE_QUERY, 24'hFFFFFF, 0, 32'hFFFFFFFF);
        queue_fixed(pdf_pkg::MODE_PUT, 0, 0, 32'h0);
        queue_fixed(pdf_pkg::MODE_PUT, 24'hFFFFFF, 15, 32'hFFFFFFFF);
        queue_fixed(pdf_pkg::MODE_QUERY, 0, 15, 32'h0);
        queue_fixed(pdf_pkg::MODE_GET, 0, 0, 32'h0);
        queue_fixed(pdf_pkg::MODE_CLEAR, 24'hFFFFFF, 15, 32'hFFFFFFFF);
        queue_fixed(pdf_pkg::MODE_QUERY, 0, 15, 32'h0);
        queue_fixed(pdf_pkg::MODE_GET, 0, 0, 32'h0);
        for (int i = 0; i < 120; i++)
        begin
            queue_op(random_op(70));
            // the test stops queueing until the block has answered everything
            if (i == 60)
                wait_for_drain();
        end
        wait_for_drain();

        // exact fit at the limit is taken, one byte more is refused
        write_reg(pdf_pkg::REG_BYTE_LIMIT, 32'd1000);
        write_reg(pdf_pkg::REG_OVERHEAD, 32'd0);
        queue_fixed(pdf_pkg::MODE_CLEAR, 0, 0, 32'h0);
        queue_fixed(pdf_pkg::MODE_PUT, 600, 2, $urandom);
        queue_fixed(pdf_pkg::MODE_PUT, 401, 2, $urandom);
        queue_fixed(pdf_pkg::MODE_PUT, 400, 5, $urandom);
        queue_fixed(pdf_pkg::MODE_PUT, 0, 5, $urandom);
        queue_fixed(pdf_pkg::MODE_QUERY, 0, 5, 32'h0);
        repeat (4) queue_fixed(pdf_pkg::MODE_GET, 0, 0, 32'h0);
        queue_fixed(pdf_pkg::MODE_PUT, 10, 3, $urandom);
        wait_for_drain();

        // larger overhead than was charged: total floors at zero
        write_reg(pdf_pkg::REG_OVERHEAD, 32'd255);
        queue_fixed(pdf_pkg::MODE_GET, 0, 0, 32'h0);
        queue_fixed(pdf_pkg::MODE_CLEAR, 0, 0, 32'h0);
        wait_for_drain();

        // fill the store past full with no idling
        write_reg(pdf_pkg::REG_BYTE_LIMIT, 32'hFFFFFFFF);
        write_reg(pdf_pkg::REG_OVERHEAD, 32'd0);
        no_idle = 1'b1;
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            op      = random_op(0);
            op.mode = pdf_pkg::MODE_PUT;
            op.size = pdf_pkg::SIZE_W'($urandom_range(0, 4095));
            queue_op(op);
        end
        for (int i = 0; i < 3; i++)
            queue_fixed(pdf_pkg::MODE_QUERY, 0, $urandom_range(0, 15), $urandom);
        repeat (2) queue_fixed(pdf_pkg::MODE_GET, 0, 0, 32'h0);
        wait_for_drain();
        no_idle = 1'b0;

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_reg(pdf_pkg::REG_BYTE_LIMIT, 32'd0);
                1: write_reg(pdf_pkg::REG_BYTE_LIMIT, $urandom_range(0, 20000));
                2: write_reg(pdf_pkg::REG_BYTE_LIMIT, $urandom);
                3: write_reg(pdf_pkg::REG_BYTE_LIMIT, $urandom_range(1000, 100000));
                default: write_reg(pdf_pkg::REG_BYTE_LIMIT, 32'hFFFFFFFF);
            endcase
            write_reg(pdf_pkg::REG_OVERHEAD, (phase == 1) ? 32'd255 : $urandom_range(0, 255));
            for (int i = 0; i < 40; i++)
                queue_op(random_op(10));
            wait_for_drain();
        end

        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("expected results left over");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pdf_pkg.sv
hw/rtl/packet_descriptor_fifo.sv
test/packet_descriptor_fifo_tb.sv
